// ===== hw/rtl/http2_frame_deframer_top_defines.svh =====
// ---------------------------------------------------------------------------
// HTTP/2 frame deframer assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled while
// arst_n is low.
// ---------------------------------------------------------------------------
`ifndef HTTP2_FRAME_DEFRAMER_TOP_DEFINES_SVH
`define HTTP2_FRAME_DEFRAMER_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define H2FD_ASSERT_NOW(lbl, ant, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ant) |-> (cons)) \
		else $error("h2fd: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define H2FD_ASSERT_NXT(lbl, ant, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ant) |=> (cons)) \
		else $error("h2fd: next-cycle check failed");

`endif

// ===== hw/rtl/h2fd_pkg.sv =====
// ---------------------------------------------------------------------------
// HTTP/2 frame deframer package
// Types and fixed constants shared by the deframer modules.
// ---------------------------------------------------------------------------
`default_nettype none

package h2fd_pkg;

	localparam int HEADER_SIZE = 9;
	localparam int STORE_DEPTH = HEADER_SIZE - 1;
	localparam int STORE_IDX_W = $clog2(STORE_DEPTH);
	localparam int CNT_W       = $clog2(HEADER_SIZE);
	localparam int LEN_W       = 24;
	localparam int ID_W        = 31;

	localparam logic [LEN_W-1:0] MAX_LEN_RESET = 24'd16384;

	localparam logic [7:0] TYPE_HEADERS       = 8'd1;
	localparam logic [7:0] TYPE_SETTINGS      = 8'd4;
	localparam logic [7:0] TYPE_PUSH_PROMISE  = 8'd5;
	localparam logic [7:0] TYPE_WINDOW_UPDATE = 8'd8;
	localparam logic [7:0] TYPE_MAX_KNOWN     = 8'd9;

	typedef enum logic [1:0] {
		KIND_HEADER  = 2'd0,
		KIND_PAYLOAD = 2'd1,
		KIND_ERROR   = 2'd2
	} kind_t;

	typedef struct packed {
		kind_t            result_kind;
		logic [LEN_W-1:0] frame_length;
		logic [7:0]       frame_type;
		logic [7:0]       frame_flags;
		logic [ID_W-1:0]  stream_id;
		logic [7:0]       payload_byte;
		logic             last;
		logic             stream_error;
		logic             type_known;
	} res_t;

endpackage

`default_nettype wire

// ===== hw/rtl/h2fd_channels.sv =====
// ---------------------------------------------------------------------------
// HTTP/2 frame deframer channels
// Valid/ready interfaces for the input byte stream and the result stream.
// ---------------------------------------------------------------------------
`default_nettype none

interface h2fd_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;

	modport source (output valid, output data_byte, input ready);
	modport sink (input valid, input data_byte, output ready);
endinterface

interface h2fd_result_if;
	logic                      valid;
	logic                      ready;
	logic [1:0]                result_kind;
	logic [h2fd_pkg::LEN_W-1:0] frame_length;
	logic [7:0]                frame_type;
	logic [7:0]                frame_flags;
	logic [h2fd_pkg::ID_W-1:0]  stream_id;
	logic [7:0]                payload_byte;
	logic                      last;
	logic                      stream_error;
	logic                      type_known;

	modport source (
		output valid, output result_kind, output frame_length, output frame_type,
		output frame_flags, output stream_id, output payload_byte, output last,
		output stream_error, output type_known, input ready
	);
	modport sink (
		input valid, input result_kind, input frame_length, input frame_type,
		input frame_flags, input stream_id, input payload_byte, input last,
		input stream_error, input type_known, output ready
	);
endinterface

`default_nettype wire

// ===== hw/rtl/http2_frame_deframer_top.sv =====
// ---------------------------------------------------------------------------
// HTTP/2 frame deframer
// Path: parser input register, then the result register. Throughput: one
// byte per cycle while the result side keeps up; the result register and
// its skid entry keep input ready off the result channel's ready.
// Reset: arst_n clears the header counter, payload state and halt flag,
// and sets the maximum frame length to 16384.
// ---------------------------------------------------------------------------
`default_nettype none

module http2_frame_deframer_top (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       cfg_wr_en,
	input  wire logic [h2fd_pkg::LEN_W-1:0] cfg_wr_data,
	h2fd_byte_if.sink                       byte_ch,
	h2fd_result_if.source                   result_ch
);

	logic [h2fd_pkg::LEN_W-1:0] max_len_q;
	logic                       res_valid;
	logic                       res_ready;
	h2fd_pkg::res_t             res;
	h2fd_pkg::res_t             out_res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= h2fd_pkg::MAX_LEN_RESET;
		end else if (cfg_wr_en) begin
			max_len_q <= cfg_wr_data;
		end
	end

	h2fd_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.max_len   (max_len_q),
		.in_valid  (byte_ch.valid),
		.in_byte   (byte_ch.data_byte),
		.in_ready  (byte_ch.ready),
		.res_valid (res_valid),
		.res       (res),
		.res_ready (res_ready)
	);

	h2fd_out_skid u_out_skid (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (res_valid),
		.in_res    (res),
		.in_ready  (res_ready),
		.out_valid (result_ch.valid),
		.out_res   (out_res),
		.out_ready (result_ch.ready)
	);

	assign result_ch.result_kind  = out_res.result_kind;
	assign result_ch.frame_length = out_res.frame_length;
	assign result_ch.frame_type   = out_res.frame_type;
	assign result_ch.frame_flags  = out_res.frame_flags;
	assign result_ch.stream_id    = out_res.stream_id;
	assign result_ch.payload_byte = out_res.payload_byte;
	assign result_ch.last         = out_res.last;
	assign result_ch.stream_error = out_res.stream_error;
	assign result_ch.type_known   = out_res.type_known;

endmodule

`default_nettype wire

// ===== hw/rtl/h2fd_parser.sv =====
// ---------------------------------------------------------------------------
// HTTP/2 frame deframer parser
// Input register, header gathering, header decode and payload tracking.
// ---------------------------------------------------------------------------
`default_nettype none

module h2fd_parser (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic [h2fd_pkg::LEN_W-1:0] max_len,
	input  wire logic                       in_valid,
	input  wire logic [7:0]                 in_byte,
	output logic                            in_ready,
	output logic                            res_valid,
	output h2fd_pkg::res_t                  res,
	input  wire logic                       res_ready
);

	logic                            valid_s1;
	logic [7:0]                      byte_s1;
	logic [7:0]                      store_q [h2fd_pkg::STORE_DEPTH];
	logic [h2fd_pkg::CNT_W-1:0]      header_count_q;
	logic                            in_payload_q;
	logic [h2fd_pkg::LEN_W-1:0]      bytes_left_q;
	logic [h2fd_pkg::LEN_W-1:0]      held_length_q;
	logic [7:0]                      held_type_q;
	logic [7:0]                      held_flags_q;
	logic [h2fd_pkg::ID_W-1:0]       held_stream_q;
	logic                            halted_q;

	logic [h2fd_pkg::LEN_W-1:0]      hdr_len;
	logic [h2fd_pkg::ID_W-1:0]       hdr_id;
	logic                            hdr_done;
	logic                            decode;
	logic                            too_long;
	logic                            ctrl_type;
	logic                            has_res;
	logic                            adv;
	logic                            step;

	assign hdr_len  = {store_q[0], store_q[1], store_q[2]};
	assign hdr_id   = {store_q[5][6:0], store_q[6], store_q[7], byte_s1};
	assign hdr_done = (header_count_q == h2fd_pkg::CNT_W'(h2fd_pkg::STORE_DEPTH));
	assign decode   = !halted_q && !in_payload_q && hdr_done;
	assign too_long = (hdr_len > max_len);
	assign has_res  = !halted_q && (in_payload_q || hdr_done);

	assign ctrl_type = (store_q[3] == h2fd_pkg::TYPE_HEADERS) ||
		(store_q[3] == h2fd_pkg::TYPE_SETTINGS) ||
		(store_q[3] == h2fd_pkg::TYPE_PUSH_PROMISE) ||
		(store_q[3] == h2fd_pkg::TYPE_WINDOW_UPDATE);

	assign adv       = valid_s1 && (!has_res || res_ready);
	assign step      = adv && !halted_q;
	assign in_ready  = !valid_s1 || adv;
	assign res_valid = valid_s1 && has_res;

	always_comb begin
		res = '0;
		if (decode) begin
			res.result_kind  = too_long ? h2fd_pkg::KIND_ERROR : h2fd_pkg::KIND_HEADER;
			res.frame_length = hdr_len;
			res.frame_type   = store_q[3];
			res.frame_flags  = store_q[4];
			res.stream_id    = hdr_id;
			res.last         = too_long || (hdr_len == '0);
			res.stream_error = too_long && (hdr_id != '0) && !ctrl_type;
		end else begin
			res.result_kind  = h2fd_pkg::KIND_PAYLOAD;
			res.frame_length = held_length_q;
			res.frame_type   = held_type_q;
			res.frame_flags  = held_flags_q;
			res.stream_id    = held_stream_q;
			res.payload_byte = byte_s1;
			res.last         = (bytes_left_q <= h2fd_pkg::LEN_W'(1));
		end
		res.type_known = (res.frame_type <= h2fd_pkg::TYPE_MAX_KNOWN);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= in_byte;
		end
		if (step && !in_payload_q && !hdr_done) begin
			store_q[header_count_q[h2fd_pkg::STORE_IDX_W-1:0]] <= byte_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_count_q <= '0;
			in_payload_q   <= 1'b0;
			bytes_left_q   <= '0;
			held_length_q  <= '0;
			held_type_q    <= '0;
			held_flags_q   <= '0;
			held_stream_q  <= '0;
			halted_q       <= 1'b0;
		end else if (step) begin
			if (in_payload_q) begin
				if (bytes_left_q != '0) begin
					bytes_left_q <= bytes_left_q - h2fd_pkg::LEN_W'(1);
				end
				if (bytes_left_q <= h2fd_pkg::LEN_W'(1)) begin
					in_payload_q <= 1'b0;
				end
			end else if (!hdr_done) begin
				header_count_q <= header_count_q + h2fd_pkg::CNT_W'(1);
			end else begin
				header_count_q <= '0;
				held_length_q  <= hdr_len;
				held_type_q    <= store_q[3];
				held_flags_q   <= store_q[4];
				held_stream_q  <= hdr_id;
				if (too_long) begin
					halted_q <= 1'b1;
				end else if (hdr_len != '0) begin
					in_payload_q <= 1'b1;
					bytes_left_q <= hdr_len;
				end
			end
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/h2fd_out_skid.sv =====
// ---------------------------------------------------------------------------
// HTTP/2 frame deframer result register
// Output register with a skid entry so that ready toward the parser is
// taken from a register.
// ---------------------------------------------------------------------------
`default_nettype none

module h2fd_out_skid (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	input  h2fd_pkg::res_t in_res,
	output logic          in_ready,
	output logic          out_valid,
	output h2fd_pkg::res_t out_res,
	input  wire logic     out_ready
);

	logic           main_valid_q;
	logic           skid_valid_q;
	h2fd_pkg::res_t main_q;
	h2fd_pkg::res_t skid_q;
	logic           push;
	logic           pop;

	assign in_ready  = !skid_valid_q;
	assign out_valid = main_valid_q;
	assign out_res   = main_q;
	assign push      = in_valid && in_ready;
	assign pop       = main_valid_q && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (!main_valid_q || pop) begin
				main_valid_q <= push || skid_valid_q;
				skid_valid_q <= 1'b0;
			end else if (push) begin
				skid_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!main_valid_q || pop) begin
			main_q <= skid_valid_q ? skid_q : in_res;
		end else if (push) begin
			skid_q <= in_res;
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/h2fd_checker.sv =====
// ---------------------------------------------------------------------------
// HTTP/2 frame deframer checker
// Port-level checks on the result stream, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

`include "http2_frame_deframer_top_defines.svh"

module h2fd_checker (
	input wire logic                       clk,
	input wire logic                       arst_n,
	input wire logic                       out_valid,
	input wire logic                       out_ready,
	input wire logic [1:0]                 result_kind,
	input wire logic [h2fd_pkg::LEN_W-1:0] frame_length,
	input wire logic [7:0]                 payload_byte,
	input wire logic                       last,
	input wire logic                       stream_error
);

	logic out_stall;
	logic out_fire;
	logic is_header;
	logic is_payload;
	logic is_error;

	assign out_stall  = out_valid && !out_ready;
	assign out_fire   = out_valid && out_ready;
	assign is_header  = out_valid && (result_kind == h2fd_pkg::KIND_HEADER);
	assign is_payload = out_valid && (result_kind == h2fd_pkg::KIND_PAYLOAD);
	assign is_error   = out_valid && (result_kind == h2fd_pkg::KIND_ERROR);

	`H2FD_ASSERT_NXT(a_stall_holds, out_stall, out_valid && $stable(result_kind) && $stable(payload_byte))
	`H2FD_ASSERT_NOW(a_payload_zero, out_valid && !is_payload, payload_byte == 8'd0)
	`H2FD_ASSERT_NOW(a_serr_only_error, out_valid && !is_error, !stream_error)
	`H2FD_ASSERT_NOW(a_header_last, is_header, last == (frame_length == '0))
	`H2FD_ASSERT_NXT(a_error_final, out_fire && is_error, !out_valid)

endmodule

bind http2_frame_deframer_top h2fd_checker u_h2fd_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (result_ch.valid),
	.out_ready    (result_ch.ready),
	.result_kind  (result_ch.result_kind),
	.frame_length (result_ch.frame_length),
	.payload_byte (result_ch.payload_byte),
	.last         (result_ch.last),
	.stream_error (result_ch.stream_error)
);

`default_nettype wire

// ===== bench/http2_frame_deframer_top_tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// HTTP/2 frame deframer testbench
// Sends frame headers and payloads into the deframer one byte per item,
// with random gaps on the input and random stalls on the result side. Each
// accepted byte is decoded by a local frame decoder, and every returned
// result is checked against the oldest decoded expectation. The run covers
// several length limits, a long result-side hold-off, and it ends with a
// frame size error and the bytes that the halted block must ignore.
// ---------------------------------------------------------------------------

module http2_frame_deframer_top_tb;

	localparam int STALL_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 4;
	localparam int HOLD_OFF_CYCLES = 300;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_wr_en;
	logic [h2fd_pkg::LEN_W-1:0] cfg_wr_data;

	h2fd_byte_if byte_ch ();
	h2fd_result_if result_ch ();

	http2_frame_deframer_top i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.byte_ch    (byte_ch),
		.result_ch  (result_ch)
	);

	always #1 clk = ~clk;

	logic [h2fd_pkg::LEN_W-1:0] max_len;
	logic [7:0]                 hdr_bytes [h2fd_pkg::STORE_DEPTH];
	int                         hdr_count;
	bit                         in_payload;
	bit                         halted;
	logic [h2fd_pkg::LEN_W-1:0] bytes_left;
	logic [h2fd_pkg::LEN_W-1:0] cur_length;
	logic [7:0]                 cur_type;
	logic [7:0]                 cur_flags;
	logic [h2fd_pkg::ID_W-1:0]  cur_stream;
	h2fd_pkg::res_t             frame_results_due [$];

	bit send_gaps;
	bit recv_stalls;
	int hold_off_requests;
	int hold_off_taken;
	int hold_off_cycles;
	int stall_left;
	int idle_cycles;
	int fail_count;
	int bytes_sent;

	function automatic void push_result(h2fd_pkg::kind_t kind, logic [7:0] pbyte,
			logic is_last, logic serr);
		h2fd_pkg::res_t r;
		r.result_kind  = kind;
		r.frame_length = cur_length;
		r.frame_type   = cur_type;
		r.frame_flags  = cur_flags;
		r.stream_id    = cur_stream;
		r.payload_byte = pbyte;
		r.last         = is_last;
		r.stream_error = serr;
		r.type_known   = (cur_type <= h2fd_pkg::TYPE_MAX_KNOWN);
		frame_results_due.push_back(r);
	endfunction

	function automatic void deframe_byte(logic [7:0] b);
		logic is_last;
		logic serr;
		if (halted) begin
		end else if (in_payload) begin
			is_last = (bytes_left <= h2fd_pkg::LEN_W'(1));
			if (bytes_left > 0)
				bytes_left = bytes_left - h2fd_pkg::LEN_W'(1);
			if (is_last)
				in_payload = 1'b0;
			push_result(h2fd_pkg::KIND_PAYLOAD, b, is_last, 1'b0);
		end else if (hdr_count < h2fd_pkg::STORE_DEPTH) begin
			hdr_bytes[hdr_count] = b;
			hdr_count++;
		end else begin
			hdr_count  = 0;
			cur_length = {hdr_bytes[0], hdr_bytes[1], hdr_bytes[2]};
			cur_type   = hdr_bytes[3];
			cur_flags  = hdr_bytes[4];
			cur_stream = {hdr_bytes[5][6:0], hdr_bytes[6], hdr_bytes[7], b};
			if (cur_length > max_len) begin
				// Stream id zero and the connection-scoped types make it a connection error.
				serr = (cur_stream != '0) && !(cur_type inside {h2fd_pkg::TYPE_HEADERS,
					h2fd_pkg::TYPE_SETTINGS, h2fd_pkg::TYPE_PUSH_PROMISE,
					h2fd_pkg::TYPE_WINDOW_UPDATE});
				halted = 1'b1;
				push_result(h2fd_pkg::KIND_ERROR, 8'h00, 1'b1, serr);
			end else if (cur_length > 0) begin
				in_payload = 1'b1;
				bytes_left = cur_length;
				push_result(h2fd_pkg::KIND_HEADER, 8'h00, 1'b0, 1'b0);
			end else begin
				push_result(h2fd_pkg::KIND_HEADER, 8'h00, 1'b1, 1'b0);
			end
		end
	endfunction

	function automatic string format_result(h2fd_pkg::res_t r);
		return $sformatf({"kind=%0d len=%0d type=%0d flags=%02h id=%08h ",
			"byte=%02h last=%0b serr=%0b known=%0b"},
			r.result_kind, r.frame_length, r.frame_type, r.frame_flags, r.stream_id,
			r.payload_byte, r.last, r.stream_error, r.type_known);
	endfunction

	function automatic void check_result();
		h2fd_pkg::res_t got;
		h2fd_pkg::res_t want;
		got.result_kind  = h2fd_pkg::kind_t'(result_ch.result_kind);
		got.frame_length = result_ch.frame_length;
		got.frame_type   = result_ch.frame_type;
		got.frame_flags  = result_ch.frame_flags;
		got.stream_id    = result_ch.stream_id;
		got.payload_byte = result_ch.payload_byte;
		got.last         = result_ch.last;
		got.stream_error = result_ch.stream_error;
		got.type_known   = result_ch.type_known;
		if (frame_results_due.size() == 0) begin
			fail_count++;
			if (fail_count <= 10)
				$display("unexpected result: %s", format_result(got));
		end else begin
			want = frame_results_due.pop_front();
			if (got.result_kind !== want.result_kind ||
					got.frame_length !== want.frame_length ||
					got.frame_type !== want.frame_type || got.frame_flags !== want.frame_flags ||
					got.stream_id !== want.stream_id || got.payload_byte !== want.payload_byte ||
					got.last !== want.last || got.stream_error !== want.stream_error ||
					got.type_known !== want.type_known) begin
				fail_count++;
				if (fail_count <= 10) begin
					$display("result mismatch at %0t", $realtime);
					$display("  expected %s", format_result(want));
					$display("  actual   %s", format_result(got));
				end
			end
		end
	endfunction

	always @(posedge clk) begin
		if (arst_n && result_ch.valid && result_ch.ready)
			check_result();
		if (hold_off_taken != hold_off_requests) begin
			hold_off_taken = hold_off_requests;
			hold_off_cycles = HOLD_OFF_CYCLES;
		end
		if (hold_off_cycles > 0) begin
			result_ch.ready <= 1'b0;
			hold_off_cycles--;
		end else if (stall_left > 0) begin
			result_ch.ready <= 1'b0;
			stall_left--;
		end else if (recv_stalls && $urandom_range(0, 4) == 0) begin
			result_ch.ready <= 1'b0;
			stall_left = $urandom_range(0, 8);
		end else begin
			result_ch.ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (byte_ch.valid && byte_ch.ready) || (result_ch.valid && result_ch.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("timeout: no item moved for %0d cycles", STALL_LIMIT);
			$display("DONE: errors detected");
			$finish;
		end
	end

	task automatic send_byte(input logic [7:0] b);
		byte_ch.valid     <= 1'b1;
		byte_ch.data_byte <= b;
		do @(posedge clk); while (!byte_ch.ready);
		deframe_byte(b);
		bytes_sent++;
		if (send_gaps && $urandom_range(0, 3) == 0) begin
			byte_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
	endtask

	task automatic send_header_bytes(input logic [71:0] hdr, input int first, input int count);
		for (int i = first; i < first + count; i++)
			send_byte(hdr[71 - 8 * i -: 8]);
	endtask

	task automatic send_frame(input logic [23:0] len, input logic [7:0] ftype,
			input logic [7:0] flags, input logic [31:0] sid);
		send_header_bytes({len, ftype, flags, sid}, 0, h2fd_pkg::HEADER_SIZE);
		for (int i = 0; i < int'(len); i++)
			send_byte(8'($urandom));
	endtask

	task automatic send_random_frame(input int long_len);
		logic [23:0] len;
		logic [7:0]  ftype;
		logic [31:0] sid;
		ftype = ($urandom_range(0, 9) < 6)
			? 8'($urandom_range(0, int'(h2fd_pkg::TYPE_MAX_KNOWN))) : 8'($urandom);
		sid = $urandom;
		case ($urandom_range(0, 7))
			0: sid[30:0] = '0;
			1: sid[30:0] = '1;
			default: ;
		endcase
		len = ($urandom_range(0, 9) == 0) ? 24'($urandom_range(0, long_len))
			: 24'($urandom_range(0, 20));
		if (len > max_len)
			len = max_len;
		send_frame(len, ftype, 8'($urandom), sid);
	endtask

	task automatic wait_idle();
		byte_ch.valid <= 1'b0;
		while (frame_results_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_limit(input logic [h2fd_pkg::LEN_W-1:0] value);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		max_len = value;
	endtask

	task automatic test_header_fields();
		send_frame(24'd0, 8'h00, 8'hFF, 32'h0000_0000);
		send_frame(24'd1, h2fd_pkg::TYPE_MAX_KNOWN, 8'h00, 32'hFFFF_FFFF);
		send_frame(24'd2, h2fd_pkg::TYPE_MAX_KNOWN + 8'd1, 8'h5A, 32'h8000_0001);
		send_frame(24'd3, 8'hFF, 8'hA5, 32'h7FFF_FFFF);
		wait_idle();
	endtask

	task automatic test_low_limits();
		logic [71:0] hdr;
		write_limit(24'd40);
		send_frame(24'd40, h2fd_pkg::TYPE_HEADERS, 8'h01, 32'd3);
		send_frame(24'd0, h2fd_pkg::TYPE_SETTINGS, 8'h00, 32'd0);
		// The limit written between header bytes must apply to this header.
		hdr = {24'd25, h2fd_pkg::TYPE_WINDOW_UPDATE, 8'h04, 32'd5};
		send_header_bytes(hdr, 0, 5);
		wait_idle();
		write_limit(24'd25);
		send_header_bytes(hdr, 5, h2fd_pkg::HEADER_SIZE - 5);
		for (int i = 0; i < 25; i++)
			send_byte(8'($urandom));
		wait_idle();
		write_limit(24'd0);
		send_frame(24'd0, h2fd_pkg::TYPE_PUSH_PROMISE, 8'h80, 32'h0000_0100);
		wait_idle();
	endtask

	task automatic test_random_stream();
		int start;
		for (int round = 0; round < 6; round++) begin
			case (round % 3)
				0: write_limit(h2fd_pkg::MAX_LEN_RESET);
				1: write_limit(24'hFF_FFFF);
				default: write_limit(24'($urandom_range(int'(h2fd_pkg::MAX_LEN_RESET),
					24'hFF_FFFF)));
			endcase
			start = bytes_sent;
			while (bytes_sent - start < 205) begin
				if ($urandom_range(0, 7) == 0)
					send_gaps = !send_gaps;
				if ($urandom_range(0, 7) == 0)
					recv_stalls = !recv_stalls;
				send_random_frame(200);
			end
			wait_idle();
		end
	endtask

	task automatic test_backpressure();
		send_gaps = 1'b0;
		recv_stalls = 1'b0;
		hold_off_requests++;
		repeat (3)
			send_frame(24'd20, h2fd_pkg::TYPE_MAX_KNOWN, 8'($urandom), $urandom);
		wait_idle();
	endtask

	task automatic test_no_idle();
		send_gaps = 1'b0;
		recv_stalls = 1'b0;
		repeat (8)
			send_random_frame(30);
		wait_idle();
	endtask

	task automatic test_size_error();
		logic [7:0]  ftype;
		logic [31:0] sid;
		write_limit(h2fd_pkg::MAX_LEN_RESET);
		case ($urandom_range(0, 2))
			0: begin
				ftype = 8'($urandom);
				sid = {1'($urandom), 31'd0};
			end
			1: begin
				case ($urandom_range(0, 3))
					0: ftype = h2fd_pkg::TYPE_HEADERS;
					1: ftype = h2fd_pkg::TYPE_SETTINGS;
					2: ftype = h2fd_pkg::TYPE_PUSH_PROMISE;
					default: ftype = h2fd_pkg::TYPE_WINDOW_UPDATE;
				endcase
				sid = $urandom | 32'd1;
			end
			default: begin
				do ftype = 8'($urandom);
				while (ftype inside {h2fd_pkg::TYPE_HEADERS, h2fd_pkg::TYPE_SETTINGS,
					h2fd_pkg::TYPE_PUSH_PROMISE, h2fd_pkg::TYPE_WINDOW_UPDATE});
				sid = $urandom | 32'd1;
			end
		endcase
		send_header_bytes({24'hFF_FFFF, ftype, 8'($urandom), sid}, 0, h2fd_pkg::HEADER_SIZE);
		// The block is halted now and must swallow everything that follows.
		repeat (30)
			send_byte(8'($urandom));
		wait_idle();
	endtask

	initial begin
		arst_n            <= 1'b0;
		cfg_wr_en         <= 1'b0;
		cfg_wr_data       <= '0;
		byte_ch.valid     <= 1'b0;
		byte_ch.data_byte <= '0;
		max_len    = h2fd_pkg::MAX_LEN_RESET;
		hdr_count  = 0;
		in_payload = 1'b0;
		halted     = 1'b0;
		bytes_left = '0;
		cur_length = '0;
		cur_type   = '0;
		cur_flags  = '0;
		cur_stream = '0;
		send_gaps   = 1'b1;
		recv_stalls = 1'b1;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_header_fields();
		test_low_limits();
		test_random_stream();
		test_backpressure();
		test_no_idle();
		test_size_error();

		repeat (8) @(posedge clk);
		if (fail_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
